[hw/rtl/ukh_pkg.sv]
// Shared types, constants and helpers for the katakana-to-hiragana byte converter.
package ukh_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_PTR_W = QUEUE_IDX_W + 1;

   localparam logic [7:0] LEAD_KANA    = 8'hE3;
   localparam logic [7:0] SECOND_LOW   = 8'h82;
   localparam logic [7:0] SECOND_HIGH  = 8'h83;
   localparam logic [7:0] THIRD_MIN_82 = 8'hA1;
   localparam logic [7:0] THIRD_MAX_83 = 8'hB6;
   localparam logic [7:0] THIRD_VU_A   = 8'hBD;
   localparam logic [7:0] THIRD_VU_B   = 8'hBE;
   localparam logic [7:0] THIRD_SPLIT  = 8'hA0;
   localparam logic [7:0] THIRD_SHIFT  = 8'h20;

   // number of bytes carried by one queue entry
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] cnt;
      logic       last;
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      entry_type wr_data;
   } q_wr_type;

   typedef struct packed {
      logic      valid;
      entry_type data;
   } q_rd_type;

   // continuation bytes that follow a lead byte
   function automatic logic [2:0] lead_skip(input logic [7:0] b);
      logic [2:0] r;
      priority if (b < 8'hC0) r = 3'd0;
      else if (b < 8'hE0)     r = 3'd1;
      else if (b < 8'hF0)     r = 3'd2;
      else if (b < 8'hF8)     r = 3'd3;
      else if (b < 8'hFC)     r = 3'd4;
      else if (b < 8'hFE)     r = 3'd5;
      else                    r = 3'd0;
      return r;
   endfunction

endpackage

[hw/rtl/utf8_katakana_to_hiragana.sv]
// Top level of the UTF-8 katakana-to-hiragana stream converter.
//
// Usage:
//   Request side is a queue write port: drive req_data (one byte plus an
//   end-of-string flag) with req_push; the request is taken on a clock edge
//   where req_push is high and req_full is low. One request per cycle.
//   Result side is a queue read port: while rsp_empty is low, rsp_data holds
//   the oldest output byte; rsp_pop takes it.
//   Katakana characters (E3 82 A1..E3 83 B6, E3 83 BD/BE) are rewritten to
//   hiragana; all other bytes pass unchanged. A string that ends inside a
//   character flushes its held bytes unconverted, last one flagged.
// Path: the first result byte of an accepted request reaches rsp_data through
//   the entry queue, the serializer work register and the output register;
//   held kana bytes appear once the third byte arrives.
// Throughput: one request per cycle; one result byte per cycle. A request
//   can yield up to three bytes, so the output port sets the sustained rate.
// Stall: if rsp_pop stays low the 4-entry queue fills and req_full rises;
//   nothing is dropped.
// Reset: synchronous, active high; clears the character state, the queue
//   and the output register.
module utf8_katakana_to_hiragana import ukh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full;
   logic     q_rd_en;

   // classifier: tracks character boundaries and kana sequences
   ukh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_wr     (q_wr),
      .q_full   (q_full)
   );

   // decouples the classifier from output backpressure
   ukh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .q_full  (q_full),
      .q_rd    (q_rd),
      .q_rd_en (q_rd_en)
   );

   // serializer: one byte per cycle into the output register while it is free
   ukh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rd      (q_rd),
      .q_rd_en   (q_rd_en),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/ukh_front.sv]
// Front end: walks UTF-8 characters, holds E3 kana sequences and builds output entries.
module ukh_front import ukh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_data,
   output q_wr_type q_wr,
   input  logic     q_full
);

   typedef enum logic [2:0] {
      PH_NONE   = 3'b001,
      PH_LEAD   = 3'b010,
      PH_SECOND = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] skip_ff, skip_in;
   logic [7:0] held_ff, held_in;

   logic       accept;
   logic       emit;
   logic       is_second;
   logic       conv;
   logic [7:0] b;
   logic       last;
   logic [7:0] s_out, t_out;
   entry_type  ent;

   assign b        = req_data.in_byte;
   assign last     = req_data.in_last;
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   assign is_second = (b == SECOND_LOW) || (b == SECOND_HIGH);

   // held second byte plus incoming third byte
   always_comb begin
      conv = (b != 8'h00) &&
             (((held_ff == SECOND_LOW) && (b >= THIRD_MIN_82)) ||
              ((held_ff == SECOND_HIGH) && (b <= THIRD_MAX_83)) ||
              ((held_ff == SECOND_HIGH) && ((b == THIRD_VU_A) || (b == THIRD_VU_B))));
      s_out = held_ff;
      t_out = b;
      if (conv) begin
         if (b >= THIRD_SPLIT) begin
            s_out = held_ff - 8'd1;
            t_out = b - THIRD_SHIFT;
         end else begin
            s_out = held_ff - 8'd2;
            t_out = b + THIRD_SHIFT;
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      held_in   = held_ff;
      emit      = 1'b0;
      ent.cnt   = CNT_ONE;
      ent.last  = last;
      ent.data0 = b;
      ent.data1 = b;
      ent.data2 = b;
      unique case (phase_ff)
         PH_LEAD: begin
            if (!last && is_second) begin
               held_in  = b;
               phase_in = PH_SECOND;
            end else begin
               emit      = 1'b1;
               ent.cnt   = CNT_TWO;
               ent.data0 = LEAD_KANA;
               ent.data1 = b;
               phase_in  = PH_NONE;
               held_in   = 8'h00;
               skip_in   = is_second ? 3'd0 : 3'd1;
            end
         end
         PH_SECOND: begin
            emit      = 1'b1;
            ent.cnt   = CNT_THREE;
            ent.data0 = LEAD_KANA;
            ent.data1 = s_out;
            ent.data2 = t_out;
            phase_in  = PH_NONE;
            skip_in   = 3'd0;
            held_in   = 8'h00;
         end
         default: begin
            phase_in = PH_NONE;
            if (skip_ff != 3'd0) begin
               skip_in = skip_ff - 3'd1;
               emit    = 1'b1;
            end else if ((b == LEAD_KANA) && !last) begin
               phase_in = PH_LEAD;
            end else begin
               emit    = 1'b1;
               skip_in = lead_skip(b);
            end
         end
      endcase
      // end of string drops any partial character state
      if (last) begin
         phase_in = PH_NONE;
         skip_in  = 3'd0;
         held_in  = 8'h00;
      end
   end

   assign q_wr.wr_en   = accept && emit;
   assign q_wr.wr_data = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NONE;
         skip_ff  <= 3'd0;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         held_ff  <= held_in;
      end
   end

   // a held character never coexists with pending continuation bytes
   a_hold_no_skip: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_NONE) |-> (skip_ff == 3'd0))
      else $error("kana held while skipping continuation bytes");

   // final byte of a string always produces an entry
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |-> q_wr.wr_en)
      else $error("string end accepted without output");

   // after a final byte the front is back at a character boundary
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> ((phase_ff == PH_NONE) && (skip_ff == 3'd0)))
      else $error("state not cleared after string end");

endmodule

[hw/rtl/ukh_queue.sv]
// Small entry queue between the classifier and the byte serializer.
module ukh_queue import ukh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  q_wr_type q_wr,
   output logic     q_full,
   output q_rd_type q_rd,
   input  logic     q_rd_en
);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] count;

   assign count      = wr_ptr_ff - rd_ptr_ff;
   assign q_full     = (count == QUEUE_PTR_W'(QUEUE_DEPTH));
   assign q_rd.valid = (count != '0);
   assign q_rd.data  = mem_ff[rd_ptr_ff[QUEUE_IDX_W-1:0]];

   always_ff @(posedge clock) begin
      if (q_wr.wr_en) begin
         mem_ff[wr_ptr_ff[QUEUE_IDX_W-1:0]] <= q_wr.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (q_wr.wr_en) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         if (q_rd_en)    rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.wr_en |-> !q_full)
      else $error("queue write while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_rd_en |-> q_rd.valid)
      else $error("queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count <= QUEUE_PTR_W'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");

endmodule

[hw/rtl/ukh_back.sv]
// Back end: splits queued entries into single bytes behind an output register.
module ukh_back import ukh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  q_rd_type q_rd,
   output logic     q_rd_en,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   entry_type  work_ff;
   logic       work_valid_ff;
   logic [1:0] pos_ff;
   rsp_type    out_ff;
   logic       out_valid_ff;

   logic       out_free;
   logic       move;
   logic       at_end;
   logic       work_done;
   logic [7:0] cur_byte;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign move      = out_free && work_valid_ff;
   assign at_end    = (pos_ff == (work_ff.cnt - 2'd1));
   assign work_done = move && at_end;
   assign q_rd_en   = q_rd.valid && (!work_valid_ff || work_done);

   always_comb begin
      unique case (pos_ff)
         2'd0:    cur_byte = work_ff.data0;
         2'd1:    cur_byte = work_ff.data1;
         default: cur_byte = work_ff.data2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_rd_en) begin
         work_ff <= q_rd.data;
      end
      if (move) begin
         out_ff.out_byte <= cur_byte;
         out_ff.out_last <= work_ff.last && at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         pos_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (q_rd_en) begin
            work_valid_ff <= 1'b1;
            pos_ff        <= 2'd0;
         end else if (work_done) begin
            work_valid_ff <= 1'b0;
            pos_ff        <= 2'd0;
         end else if (move) begin
            pos_ff <= pos_ff + 2'd1;
         end
         if (move)         out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   a_pos_in_entry: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (pos_ff < work_ff.cnt))
      else $error("byte index past entry length");

   a_work_holds: assert property (@(posedge clock) disable iff (reset)
      (work_valid_ff && !move) |=> ($stable(pos_ff) && work_valid_ff))
      else $error("serializer advanced without a free output slot");

   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (work_ff.cnt != 2'd0))
      else $error("empty entry in serializer");

endmodule
